// ===== rtl/mtd_pkg.sv =====
// ---------------------------------------------------------------------------
// mtd_pkg: shared types and constants for the multi-tap delay core
// Sizes, register codes, reset values and the read tag for the tap pipeline.
// ---------------------------------------------------------------------------
package mtd_pkg;

  localparam int DEPTH       = 262144;
  localparam int ADDR_BITS   = $clog2(DEPTH);
  localparam int SAMPLE_BITS = 24;
  localparam int DELAY_BITS  = 18;
  localparam int GAIN_BITS   = 16;
  localparam int GAIN_FRAC   = 15;
  localparam int TAP_COUNT   = 3;
  localparam int TAP_BITS    = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1;
  localparam int PHASE_BITS  = $clog2(TAP_COUNT + 1);
  localparam int IDX_BITS    = 3;
  localparam int CFG_BITS    = 18;
  localparam int PROD_BITS   = SAMPLE_BITS + GAIN_BITS;
  localparam int ACC_BITS    = PROD_BITS + 2;
  localparam int SUM_BITS    = ACC_BITS - GAIN_FRAC + 1;
  localparam int OCC_BITS    = 2;
  localparam int OCC_LIMIT   = 2;

  typedef enum logic [IDX_BITS-1:0] {
    REG_TAP1_DELAY = 3'd0,
    REG_TAP2_DELAY = 3'd1,
    REG_TAP3_DELAY = 3'd2,
    REG_TAP1_GAIN  = 3'd3,
    REG_TAP2_GAIN  = 3'd4,
    REG_TAP3_GAIN  = 3'd5
  } reg_idx_t;

  typedef logic [2:0][DELAY_BITS-1:0] delay_vec_t;
  typedef logic [2:0][GAIN_BITS-1:0]  gain_vec_t;

  localparam delay_vec_t DELAY_RESET = {18'd144000, 18'd96000, 18'd48000};
  localparam gain_vec_t  GAIN_RESET  = {16'd9830, 16'd19661, 16'd26214};

  // Travels alongside one delay memory read
  typedef struct packed {
    logic                          vld;
    logic                          hit;    // entry was written since reset
    logic                          first;
    logic                          last;
    logic [TAP_BITS-1:0]           tap;
    logic signed [SAMPLE_BITS-1:0] x;
  } tag_t;

endpackage

// ===== rtl/mtd_ram.sv =====
// ---------------------------------------------------------------------------
// mtd_ram: generic single-port RAM
// One read or one write per cycle, read data registered.
// ---------------------------------------------------------------------------
module mtd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem_r[addr] <= wdata;
      end else begin
        rdata_r <= mem_r[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/mtd_cfg.sv =====
// ---------------------------------------------------------------------------
// mtd_cfg: tap delay and gain registers
// Decode the register index and hold delays and gains.
// ---------------------------------------------------------------------------
module mtd_cfg
  import mtd_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  input  logic [IDX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0] cfg_data,
  output delay_vec_t          delays,
  output gain_vec_t           gains
);

  delay_vec_t delay_r, delay_nxt;
  gain_vec_t  gain_r, gain_nxt;

  always_comb begin
    delay_nxt = delay_r;
    gain_nxt  = gain_r;
    if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_TAP1_DELAY: delay_nxt[0] = cfg_data[DELAY_BITS-1:0];
        REG_TAP2_DELAY: delay_nxt[1] = cfg_data[DELAY_BITS-1:0];
        REG_TAP3_DELAY: delay_nxt[2] = cfg_data[DELAY_BITS-1:0];
        REG_TAP1_GAIN:  gain_nxt[0]  = cfg_data[GAIN_BITS-1:0];
        REG_TAP2_GAIN:  gain_nxt[1]  = cfg_data[GAIN_BITS-1:0];
        REG_TAP3_GAIN:  gain_nxt[2]  = cfg_data[GAIN_BITS-1:0];
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r <= DELAY_RESET;
      gain_r  <= GAIN_RESET;
    end else begin
      delay_r <= delay_nxt;
      gain_r  <= gain_nxt;
    end
  end

  assign delays = delay_r;
  assign gains  = gain_r;

endmodule

// ===== rtl/mtd_mac.sv =====
// ---------------------------------------------------------------------------
// mtd_mac: tap multiply, accumulate and output saturation
// Multiply each read by its gain, sum per sample, add the input, saturate.
// ---------------------------------------------------------------------------
module mtd_mac
  import mtd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  tag_t                   rd_tag,
  input  logic [SAMPLE_BITS-1:0] rd_data,
  input  gain_vec_t              gains,
  output logic                   res_vld,
  output logic [SAMPLE_BITS-1:0] res_data
);

  localparam logic signed [SUM_BITS-1:0] SAT_HI =
    SUM_BITS'({1'b0, {(SAMPLE_BITS-1){1'b1}}});
  localparam logic signed [SUM_BITS-1:0] SAT_LO = -SAT_HI - SUM_BITS'(1);

  logic signed [SAMPLE_BITS-1:0]          opnd;
  logic signed [GAIN_BITS-1:0]            gain_sel;
  logic signed [PROD_BITS-1:0]            prod_r;
  tag_t                                   s2_tag_r;
  logic signed [ACC_BITS-1:0]             acc_r, acc_nxt;
  logic                                   fin_vld_r;
  logic signed [SAMPLE_BITS-1:0]          fin_x_r;
  logic signed [ACC_BITS-GAIN_FRAC-1:0]   shifted;
  logic signed [SUM_BITS-1:0]             sum;

  // Never-written entries read as zero
  assign opnd     = rd_tag.hit ? $signed(rd_data) : '0;
  assign gain_sel = $signed(gains[rd_tag.tap]);

  always_ff @(posedge clk) begin
    prod_r <= opnd * gain_sel;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_tag_r.vld <= 1'b0;
    end else begin
      s2_tag_r.vld <= rd_tag.vld;
    end
    s2_tag_r.hit   <= rd_tag.hit;
    s2_tag_r.first <= rd_tag.first;
    s2_tag_r.last  <= rd_tag.last;
    s2_tag_r.tap   <= rd_tag.tap;
    s2_tag_r.x     <= rd_tag.x;
  end

  always_comb begin
    acc_nxt = acc_r;
    if (s2_tag_r.vld) begin
      acc_nxt = (s2_tag_r.first ? ACC_BITS'(0) : acc_r) + ACC_BITS'(prod_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_vld_r <= 1'b0;
    end else begin
      fin_vld_r <= s2_tag_r.vld && s2_tag_r.last;
    end
    acc_r   <= acc_nxt;
    fin_x_r <= s2_tag_r.x;
  end

  // Arithmetic shift floors toward minus infinity
  assign shifted = acc_r[ACC_BITS-1:GAIN_FRAC];
  assign sum     = SUM_BITS'(shifted) + SUM_BITS'(fin_x_r);

  always_comb begin
    if (sum > SAT_HI) begin
      res_data = SAT_HI[SAMPLE_BITS-1:0];
    end else if (sum < SAT_LO) begin
      res_data = SAT_LO[SAMPLE_BITS-1:0];
    end else begin
      res_data = sum[SAMPLE_BITS-1:0];
    end
  end

  assign res_vld = fin_vld_r;

endmodule

// ===== rtl/multi_tap_delay_core.sv =====
// ---------------------------------------------------------------------------
// multi_tap_delay_core: mono three-tap delay with Q1.15 tap gains
// Sequencing: the single delay memory port serves three tap reads, then the
//   sample write; the next transaction is taken during that write phase,
//   while the occupancy limit allows.
// Reset: registers return to default delays and gains, pointer to zero; the
//   memory is not swept, a fill mark makes unwritten entries read as zero.
// ---------------------------------------------------------------------------
module multi_tap_delay_core
  import mtd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [SAMPLE_BITS-1:0] in_sample_in,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [SAMPLE_BITS-1:0] out_sample_out,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [IDX_BITS-1:0]    cfg_index,
  input  logic [CFG_BITS-1:0]    cfg_data
);

  delay_vec_t delays;
  gain_vec_t  gains;

  // Sequencer: phases 0..TAP_COUNT-1 read one tap each, phase TAP_COUNT
  // writes the sample and advances the pointer.
  logic                          busy_r, busy_nxt;
  logic [PHASE_BITS-1:0]         phase_r, phase_nxt;
  logic signed [SAMPLE_BITS-1:0] x_r, x_nxt;
  logic [ADDR_BITS-1:0]          wp_r, wp_nxt;
  logic                          wrapped_r, wrapped_nxt;   // pointer passed DEPTH once
  logic [OCC_BITS-1:0]           occ_r, occ_nxt;           // in flight plus queued

  logic                          in_acc, out_acc;
  logic                          rd_phase, wr_phase;
  logic [TAP_BITS-1:0]           tap_sel;
  logic [ADDR_BITS-1:0]          rd_addr;
  logic                          ram_en, ram_we;
  logic [ADDR_BITS-1:0]          ram_addr;
  logic [SAMPLE_BITS-1:0]        ram_rdata;
  tag_t                          issue_tag, rd_tag_r;

  logic                          res_vld;
  logic [SAMPLE_BITS-1:0]        res_data;

  // Two-entry result queue decouples the output channel from the pipeline
  logic [SAMPLE_BITS-1:0]        q_r [2];
  logic                          q_wp_r, q_rp_r;
  logic [OCC_BITS-1:0]           q_cnt_r;

  mtd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .delays    (delays),
    .gains     (gains)
  );

  assign cfg_ready = 1'b1;

  // Accept while idle or while the last phase runs; the occupancy limit keeps
  // the queue from ever overflowing.
  assign in_ready = (!busy_r || (phase_r == PHASE_BITS'(TAP_COUNT)))
                    && (occ_r < OCC_BITS'(OCC_LIMIT));
  assign in_acc   = in_valid && in_ready;
  assign out_acc  = out_valid && out_ready;

  assign rd_phase = busy_r && (phase_r < PHASE_BITS'(TAP_COUNT));
  assign wr_phase = busy_r && (phase_r == PHASE_BITS'(TAP_COUNT));
  assign tap_sel  = phase_r[TAP_BITS-1:0];

  // Delay wraps modulo DEPTH through the address width
  assign rd_addr  = wp_r - delays[tap_sel][ADDR_BITS-1:0];

  always_comb begin
    ram_en   = rd_phase || wr_phase;
    ram_we   = wr_phase;
    ram_addr = wr_phase ? wp_r : rd_addr;

    issue_tag.vld   = rd_phase;
    issue_tag.hit   = wrapped_r || (rd_addr < wp_r);
    issue_tag.first = (phase_r == PHASE_BITS'(0));
    issue_tag.last  = (phase_r == PHASE_BITS'(TAP_COUNT - 1));
    issue_tag.tap   = tap_sel;
    issue_tag.x     = x_r;
  end

  mtd_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (x_r),
    .rdata (ram_rdata)
  );

  always_comb begin
    busy_nxt    = busy_r;
    phase_nxt   = phase_r;
    x_nxt       = x_r;
    wp_nxt      = wp_r;
    wrapped_nxt = wrapped_r;
    if (wr_phase) begin
      // advance the pointer after the store
      wp_nxt = (wp_r == ADDR_BITS'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      if (wp_r == ADDR_BITS'(DEPTH - 1)) begin
        wrapped_nxt = 1'b1;
      end
    end
    if (in_acc) begin
      busy_nxt  = 1'b1;
      phase_nxt = '0;
      x_nxt     = $signed(in_sample_in);
    end else if (wr_phase) begin
      busy_nxt  = 1'b0;
    end else if (busy_r) begin
      phase_nxt = phase_r + 1'b1;
    end
  end

  always_comb begin
    occ_nxt = occ_r;
    if (in_acc && !out_acc) begin
      occ_nxt = occ_r + 1'b1;
    end else if (!in_acc && out_acc) begin
      occ_nxt = occ_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      phase_r   <= '0;
      wp_r      <= '0;
      wrapped_r <= 1'b0;
      occ_r     <= '0;
      rd_tag_r.vld <= 1'b0;
    end else begin
      busy_r    <= busy_nxt;
      phase_r   <= phase_nxt;
      wp_r      <= wp_nxt;
      wrapped_r <= wrapped_nxt;
      occ_r     <= occ_nxt;
      rd_tag_r.vld <= issue_tag.vld;
    end
    x_r            <= x_nxt;
    // hold the tag alongside the registered read data
    rd_tag_r.hit   <= issue_tag.hit;
    rd_tag_r.first <= issue_tag.first;
    rd_tag_r.last  <= issue_tag.last;
    rd_tag_r.tap   <= issue_tag.tap;
    rd_tag_r.x     <= issue_tag.x;
  end

  mtd_mac u_mac (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_tag   (rd_tag_r),
    .rd_data  (ram_rdata),
    .gains    (gains),
    .res_vld  (res_vld),
    .res_data (res_data)
  );

  // Result queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_wp_r  <= 1'b0;
      q_rp_r  <= 1'b0;
      q_cnt_r <= '0;
    end else begin
      if (res_vld) begin
        q_wp_r <= ~q_wp_r;
      end
      if (out_acc) begin
        q_rp_r <= ~q_rp_r;
      end
      if (res_vld && !out_acc) begin
        q_cnt_r <= q_cnt_r + 1'b1;
      end else if (!res_vld && out_acc) begin
        q_cnt_r <= q_cnt_r - 1'b1;
      end
    end
    if (res_vld) begin
      q_r[q_wp_r] <= res_data;
    end
  end

  assign out_valid      = (q_cnt_r != '0);
  assign out_sample_out = q_r[q_rp_r];

endmodule
